/* hw/rtl/deq_pkg.sv */
// Package: types, constants and index helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ADDR_X_W = ADDR_W + 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int OCNT_W   = 11;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [OCNT_W-1:0]        count;
        logic                     is_empty;
    } t_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_f;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_cmd;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              byp_f;
        logic              byp_b;
        logic [DATA_W-1:0] wdata;
    } t_meta;

    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_X_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ADDR_X_W'(DEPTH)) begin
            s = s - ADDR_X_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? ADDR_W'(DEPTH - 1) : a - 1'b1;
    endfunction

endpackage

/* hw/rtl/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/deq_ctrl.sv */
// Head and count tracking, store commands and registered result status.
module deq_ctrl import deq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_req     i_req,
    output t_mem_cmd o_cmd,
    output t_meta    o_meta
);

    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        status;
    logic              full;
    logic [ADDR_W-1:0] back_off;
    t_mem_cmd          cmd;
    t_meta             r_meta;

    assign full = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        status    = ST_DONE;
        cmd.we    = 1'b0;
        cmd.waddr = r_head;
        cmd.wdata = i_req.value;
        case (i_req.req_type)
            REQ_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_head    = slot_dec(r_head);
                    n_count   = r_count + 1'b1;
                    cmd.we    = 1'b1;
                    cmd.waddr = slot_dec(r_head);
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count   = r_count + 1'b1;
                    cmd.we    = 1'b1;
                    cmd.waddr = slot_add(r_head, ADDR_W'(r_count));
                end
            end
            REQ_POP_FRONT: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_head  = slot_add(r_head, ADDR_W'(1));
                    n_count = r_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
        cmd.we      = cmd.we & i_accept;
        back_off    = (n_count == '0) ? '0 : ADDR_W'(n_count - 1'b1);
        cmd.raddr_f = n_head;
        cmd.raddr_b = slot_add(n_head, back_off);
    end

    always_ff @(posedge i_clk) begin
        r_meta.status <= status;
        r_meta.count  <= n_count;
        r_meta.empty  <= (n_count == '0);
        r_meta.byp_f  <= cmd.we && (cmd.waddr == cmd.raddr_f);
        r_meta.byp_b  <= cmd.we && (cmd.waddr == cmd.raddr_b);
        r_meta.wdata  <= cmd.wdata;
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_meta.valid <= 1'b0;
        end else begin
            r_meta.valid <= i_accept;
            if (i_accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_meta = r_meta;

endmodule

/* hw/rtl/double_ended_queue_unit.sv */
// Top level: bounded double-ended queue over a circular store.
//
//  channel   ports              handshake
//  request   start, busy, i_req accepted when start is high and busy is low
//  result    strobe, o_rsp      one strobe per item, receiver cannot hold off
//
// One request is taken every cycle; busy stays low.
// The result of a request accepted at an edge is on o_rsp, with strobe high,
// during the cycle after that edge; the store read registers set this latency.
// Front and back are read from two copies of the store, with a bypass for
// a push that lands on the slot being read in the same cycle.
// Synchronous reset empties the queue; store contents are never cleared.
module double_ended_queue_unit import deq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic strobe,
    output t_rsp o_rsp
);

    t_mem_cmd          cmd;
    t_meta             meta;
    logic [DATA_W-1:0] rd_f;
    logic [DATA_W-1:0] rd_b;
    logic [DATA_W-1:0] val_f;
    logic [DATA_W-1:0] val_b;

    assign busy = 1'b0;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start & ~busy),
        .i_req    (i_req),
        .o_cmd    (cmd),
        .o_meta   (meta)
    );

    deq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_f (
        .i_clk   (i_clk),
        .i_we    (cmd.we),
        .i_waddr (cmd.waddr),
        .i_wdata (cmd.wdata),
        .i_raddr (cmd.raddr_f),
        .o_rdata (rd_f)
    );

    deq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (cmd.we),
        .i_waddr (cmd.waddr),
        .i_wdata (cmd.wdata),
        .i_raddr (cmd.raddr_b),
        .o_rdata (rd_b)
    );

    assign val_f = meta.byp_f ? meta.wdata : rd_f;
    assign val_b = meta.byp_b ? meta.wdata : rd_b;

    always_comb begin
        o_rsp.status      = meta.status;
        o_rsp.front_value = meta.empty ? EMPTY_VALUE : signed'(val_f);
        o_rsp.back_value  = meta.empty ? EMPTY_VALUE : signed'(val_b);
        o_rsp.count       = OCNT_W'(meta.count);
        o_rsp.is_empty    = meta.empty;
    end

    assign strobe = meta.valid;

endmodule

/* test/tb_top.sv */
// Testbench for double_ended_queue_unit: directed table, then random traffic vs a shadow deque.
module tb_top;
    import deq_pkg::*;

    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam int NUM_DIR     = 20;
    localparam int MIX_ITEMS   = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 4;
    localparam int EXP_SLOTS   = 16;

    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam t_rsp NO_RSP = '0;

    typedef struct {
        t_req req;
        bit   has_exp;
        t_rsp rsp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic strobe;
    t_rsp o_rsp;

    double_ended_queue_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .strobe  (strobe),
        .o_rsp   (o_rsp)
    );

    // shadow deque
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    int unsigned sh_head  = 0;
    int unsigned sh_count = 0;

    // expected results in flight
    t_rsp exp_buf [EXP_SLOTS];
    int exp_wr = 0;
    int exp_rd = 0;

    int n_items     = 0;
    int n_results   = 0;
    int n_dropped   = 0;
    int n_underflow = 0;
    int n_errors    = 0;
    int peak_count  = 0;
    int idle_pct    = 0;
    int quiet       = 0;
    int idle_phases [3] = '{0, 51, 31};

    t_dir_row dir_tab [NUM_DIR];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_rsp deq_apply(input t_req r);
        t_rsp rsp;
        rsp = '0;
        rsp.status = ST_DONE;
        case (r.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (sh_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                    n_dropped++;
                end else if (r.req_type == REQ_PUSH_FRONT) begin
                    sh_head = (sh_head == 0) ? DEPTH - 1 : sh_head - 1;
                    shadow_mem[sh_head] = r.value;
                    sh_count++;
                end else begin
                    shadow_mem[(sh_head + sh_count) % DEPTH] = r.value;
                    sh_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (sh_count == 0) begin
                    rsp.status = ST_EMPTY;
                    n_underflow++;
                end else begin
                    if (r.req_type == REQ_POP_FRONT) begin
                        sh_head = (sh_head + 1) % DEPTH;
                    end
                    sh_count--;
                end
            end
            default: begin
            end
        endcase
        if (sh_count == 0) begin
            rsp.front_value = EMPTY_VALUE;
            rsp.back_value  = EMPTY_VALUE;
        end else begin
            rsp.front_value = shadow_mem[sh_head];
            rsp.back_value  = shadow_mem[(sh_head + sh_count - 1) % DEPTH];
        end
        rsp.count    = OCNT_W'(sh_count);
        rsp.is_empty = (sh_count == 0);
        if (sh_count > peak_count) begin
            peak_count = sh_count;
        end
        return rsp;
    endfunction

    function automatic logic [2:0] pick_req(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct) begin
            return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end
        if (r < push_pct + pop_pct) begin
            return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
        if (r < 97) begin
            return REQ_QUERY;
        end
        return 3'($urandom_range(REQ_RSVD7, REQ_RSVD5));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return '0;
            3: return EMPTY_VALUE;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input t_req r, input bit has_exp, input t_rsp fixed_rsp);
        t_rsp pred;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        pred = deq_apply(r);
        exp_buf[exp_wr % EXP_SLOTS] = has_exp ? fixed_rsp : pred;
        exp_wr++;
        n_items++;
    endtask

    task automatic rand_item(input int push_pct, input int pop_pct);
        t_req r;
        r.req_type = pick_req(push_pct, pop_pct);
        r.value    = pick_value();
        send_item(r, 1'b0, NO_RSP);
    endtask

    initial begin
        dir_tab = '{
            '{{REQ_QUERY,      32'sd0},         1'b1,
              {ST_DONE,  EMPTY_VALUE, EMPTY_VALUE, 11'd0, 1'b1}},
            '{{REQ_POP_FRONT,  32'sd0},         1'b1,
              {ST_EMPTY, EMPTY_VALUE, EMPTY_VALUE, 11'd0, 1'b1}},
            '{{REQ_POP_BACK,   MAX_VAL},        1'b1,
              {ST_EMPTY, EMPTY_VALUE, EMPTY_VALUE, 11'd0, 1'b1}},
            '{{REQ_PUSH_BACK,  MAX_VAL},        1'b1,
              {ST_DONE,  MAX_VAL,     MAX_VAL,     11'd1, 1'b0}},
            '{{REQ_PUSH_FRONT, MIN_VAL},        1'b1,
              {ST_DONE,  MIN_VAL,     MAX_VAL,     11'd2, 1'b0}},
            '{{REQ_PUSH_BACK,  EMPTY_VALUE},    1'b1,
              {ST_DONE,  MIN_VAL,     EMPTY_VALUE, 11'd3, 1'b0}},
            '{{REQ_PUSH_FRONT, 32'sd0},         1'b1,
              {ST_DONE,  32'sd0,      EMPTY_VALUE, 11'd4, 1'b0}},
            '{{REQ_QUERY,      32'sd5},         1'b1,
              {ST_DONE,  32'sd0,      EMPTY_VALUE, 11'd4, 1'b0}},
            '{{REQ_RSVD5,      32'sh5555_5555}, 1'b1,
              {ST_DONE,  32'sd0,      EMPTY_VALUE, 11'd4, 1'b0}},
            '{{REQ_RSVD6,      MIN_VAL},        1'b1,
              {ST_DONE,  32'sd0,      EMPTY_VALUE, 11'd4, 1'b0}},
            '{{REQ_RSVD7,      32'shAAAA_AAAA}, 1'b1,
              {ST_DONE,  32'sd0,      EMPTY_VALUE, 11'd4, 1'b0}},
            '{{REQ_POP_BACK,   32'sd0},         1'b1,
              {ST_DONE,  32'sd0,      MAX_VAL,     11'd3, 1'b0}},
            '{{REQ_POP_FRONT,  32'sd0},         1'b1,
              {ST_DONE,  MIN_VAL,     MAX_VAL,     11'd2, 1'b0}},
            '{{REQ_POP_FRONT,  32'sd0},         1'b1,
              {ST_DONE,  MAX_VAL,     MAX_VAL,     11'd1, 1'b0}},
            '{{REQ_POP_BACK,   32'sd0},         1'b1,
              {ST_DONE,  EMPTY_VALUE, EMPTY_VALUE, 11'd0, 1'b1}},
            '{{REQ_PUSH_FRONT, 32'sh5555_5555}, 1'b1,
              {ST_DONE,  32'sh5555_5555, 32'sh5555_5555, 11'd1, 1'b0}},
            '{{REQ_POP_BACK,   32'sd0},         1'b1,
              {ST_DONE,  EMPTY_VALUE, EMPTY_VALUE, 11'd0, 1'b1}},
            '{{REQ_PUSH_BACK,  32'sd1},         1'b0, NO_RSP},
            '{{REQ_PUSH_FRONT, MIN_VAL},        1'b0, NO_RSP},
            '{{REQ_POP_FRONT,  32'sd0},         1'b0, NO_RSP}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            send_item(dir_tab[k].req, dir_tab[k].has_exp, dir_tab[k].rsp);
        end

        // mixed traffic, leaning toward growth
        foreach (idle_phases[p]) begin
            idle_pct = idle_phases[p];
            for (int i = 0; i < MIX_ITEMS / 3; i++) begin
                rand_item(80, 15);
            end
        end

        // fill to full, push past it, then pop a few
        idle_pct = 0;
        while (sh_count < DEPTH) begin
            rand_item(100, 0);
        end
        repeat (8) rand_item(90, 0);
        repeat (8) rand_item(0, 90);

        start <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, peak occupancy %0d of %0d",
                 n_items, n_results, peak_count, DEPTH);
        $display("%0d pushes while full, %0d pops while empty, %0d mismatches",
                 n_dropped, n_underflow, n_errors);
        if (n_errors == 0 && exp_wr == exp_rd) begin
            $display("double_ended_queue_unit test passed");
        end else begin
            $display("double_ended_queue_unit test failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && strobe) begin
            n_results++;
            if (exp_wr == exp_rd) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("result with nothing pending: %p", o_rsp);
                end
            end else begin
                want = exp_buf[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (o_rsp.status      !== want.status      ||
                    o_rsp.front_value !== want.front_value ||
                    o_rsp.back_value  !== want.back_value  ||
                    o_rsp.count       !== want.count       ||
                    o_rsp.is_empty    !== want.is_empty) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch %0d (exp/got): status %0d/%0d",
                                 n_errors, want.status, o_rsp.status);
                        $display("    front %h/%h back %h/%h",
                                 want.front_value, o_rsp.front_value,
                                 want.back_value, o_rsp.back_value);
                        $display("    count %0d/%0d empty %0d/%0d",
                                 want.count, o_rsp.count, want.is_empty, o_rsp.is_empty);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || strobe) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: no activity for %0d cycles", QUIET_LIMIT);
                $display("double_ended_queue_unit test failed");
                $finish;
            end
        end
    end

endmodule
